// ===== hdl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types and constants for the bounded set span tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam int OUT_CNT_W   = 7;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [KEY_W-1:0] SIGN_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_GATHER,
    S_UPDATE
  } state_e;

  // what one cell hands to its right-hand neighbour
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } link_t;

  // gaps around a freshly inserted key, all ones where there is no neighbour
  typedef struct packed {
    logic             took;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
  } gap_t;

endpackage

// ===== hdl/bounded_set_span_tracker.sv =====
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Sorted bounded store of signed values with shortest and longest span.
// ----------------------------------------------------------------------------
// Usage:
//   A value is taken on value_i at a clock edge where start is high and busy
//   is low. Each value gives one result word, shown on the result ports for a
//   single cycle with done_o high; the receiver cannot stall it.
//   Capacity is written over the APB port at address 0 while the block is
//   idle; pready is always high and reads return the register.
// Timing:
//   A refused value (store full) gives its result in the cycle after acceptance
//   and busy never rises. An accepted value is first latched, then inserted
//   into the chain of cells (all cells compare and shift in parallel), then
//   the gaps around the new key are gathered, and last they are folded
//   into the shortest span. busy drops with done_o, so the next value may
//   follow at once; no new value is taken while busy is high.
// Reset:
//   rst_ni clears the store, the count, capacity (to zero, so every value is
//   refused until it is written) and sets the shortest gap to all ones.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker
  import bsst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_W-1:0]     value_i,
  output logic                 done_o,
  output logic                 status_o,
  output logic [OUT_CNT_W-1:0] count_o,
  output logic                 spans_valid_o,
  output logic [KEY_W-1:0]     shortest_span_o,
  output logic [KEY_W-1:0]     longest_span_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  logic [CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] gap_q, gap_d;
  logic [KEY_W-1:0] least_q, least_d;
  logic [KEY_W-1:0] greatest_q, greatest_d;
  logic [KEY_W-1:0] near_lo_q, near_lo_d;
  logic [KEY_W-1:0] near_hi_q, near_hi_d;

  logic                 done_q, done_d;
  logic                 res_status_q, res_status_d;
  logic [OUT_CNT_W-1:0] res_count_q, res_count_d;
  logic                 res_valid_q, res_valid_d;
  logic [KEY_W-1:0]     res_short_q, res_short_d;
  logic [KEY_W-1:0]     res_long_q, res_long_d;

  logic                 accept;
  logic                 full;
  logic                 ins;
  logic [31:0]          cap32;
  logic [31:0]          cnt32;
  logic [31:0]          limit32;
  logic [KEY_W-1:0]     gather_lo;
  logic [KEY_W-1:0]     gather_hi;
  logic [KEY_W-1:0]     near_min;
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_took;

  link_t link   [MAX_ENTRIES+1];
  gap_t  gaps   [MAX_ENTRIES];

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- chain
  assign link[0] = '{valid: 1'b0, key: '0};
  assign ins     = (state_q == S_INSERT);

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    bsst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (g == 0),
      .ins_i  (ins),
      .key_i  (key_q),
      .left_i (link[g]),
      .link_o (link[g+1]),
      .gap_o  (gaps[g])
    );
    assign cell_valid[g] = link[g+1].valid;
    assign cell_took[g]  = gaps[g].took;
  end

  // only the inserting cell holds gaps below all ones
  always_comb begin
    gather_lo = '1;
    gather_hi = '1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gather_lo = gather_lo & gaps[i].lo;
      gather_hi = gather_hi & gaps[i].hi;
    end
  end

  // ---------------------------------------------------------------- control
  assign busy    = (state_q != S_IDLE);
  assign accept  = start & ~busy;
  assign cap32   = 32'(capacity_q);
  assign cnt32   = 32'(count_q);
  assign limit32 = (cap32 < 32'(MAX_ENTRIES)) ? cap32 : 32'(MAX_ENTRIES);
  assign full    = (cnt32 >= limit32);
  assign near_min = (near_lo_q < near_hi_q) ? near_lo_q : near_hi_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    key_d        = key_q;
    gap_d        = gap_q;
    least_d      = least_q;
    greatest_d   = greatest_q;
    near_lo_d    = near_lo_q;
    near_hi_d    = near_hi_q;
    done_d       = 1'b0;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_valid_d  = res_valid_q;
    res_short_d  = res_short_q;
    res_long_d   = res_long_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = value_i ^ SIGN_BIAS;
          if (full) begin
            done_d       = 1'b1;
            res_status_d = 1'b1;
            res_count_d  = OUT_CNT_W'(count_q);
            res_valid_d  = (cnt32 >= 32'd2);
            res_short_d  = (cnt32 >= 32'd2) ? gap_q : '0;
            res_long_d   = (cnt32 >= 32'd2) ? greatest_q - least_q : '0;
          end else begin
            state_d = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        count_d = count_q + CNT_W'(1);
        if (count_q == '0) begin
          least_d    = key_q;
          greatest_d = key_q;
        end else begin
          if (key_q < least_q)    least_d    = key_q;
          if (key_q > greatest_q) greatest_d = key_q;
        end
        state_d = S_GATHER;
      end
      S_GATHER: begin
        near_lo_d = gather_lo;
        near_hi_d = gather_hi;
        state_d   = S_UPDATE;
      end
      S_UPDATE: begin
        gap_d        = (near_min < gap_q) ? near_min : gap_q;
        done_d       = 1'b1;
        res_status_d = 1'b0;
        res_count_d  = OUT_CNT_W'(count_q);
        res_valid_d  = (cnt32 >= 32'd2);
        res_short_d  = (cnt32 >= 32'd2) ? gap_d : '0;
        res_long_d   = (cnt32 >= 32'd2) ? greatest_q - least_q : '0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      gap_q   <= '1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      gap_q   <= gap_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    least_q      <= least_d;
    greatest_q   <= greatest_d;
    near_lo_q    <= near_lo_d;
    near_hi_q    <= near_hi_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_valid_q  <= res_valid_d;
    res_short_q  <= res_short_d;
    res_long_q   <= res_long_d;
  end

  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign count_o         = res_count_q;
  assign spans_valid_o   = res_valid_q;
  assign shortest_span_o = res_short_q;
  assign longest_span_o  = res_long_q;

  // ---------------------------------------------------------------- checks
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result word shown while an insertion is in flight");

  a_cells_match_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(cell_valid)) == cnt32)
    else $error("occupied cells disagree with count");

  a_one_taker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |=> $onehot(cell_took))
    else $error("new key not taken by exactly one cell");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("count not advanced by insertion");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt32 <= 32'(MAX_ENTRIES))
    else $error("count beyond store size");

endmodule

// ===== hdl/bsst_cell.sv =====
// ----------------------------------------------------------------------------
// bsst_cell
// One slot of the sorted chain: holds a key, inserts or shifts on request
// and records the gaps to its neighbours when it takes the new key.
// ----------------------------------------------------------------------------
module bsst_cell
  import bsst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_i,
  input  logic             ins_i,
  input  logic [KEY_W-1:0] key_i,
  input  link_t            left_i,
  output link_t            link_o,
  output gap_t             gap_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  gap_t             gap_q, gap_d;
  logic             le_left;
  logic             gt_self;
  logic             take;

  always_comb begin
    le_left = head_i | (left_i.valid & (left_i.key <= key_i));
    gt_self = ~valid_q | (key_q > key_i);
    take    = le_left & gt_self;

    valid_d = valid_q;
    key_d   = key_q;
    gap_d   = gap_q;
    if (ins_i) begin
      if (!le_left) begin
        // new key lands further left: take the neighbour's word
        valid_d = left_i.valid;
        key_d   = left_i.key;
      end else if (gt_self) begin
        valid_d = 1'b1;
        key_d   = key_i;
      end
      gap_d.took = take;
      gap_d.lo   = (take && !head_i) ? key_i - left_i.key : '1;
      gap_d.hi   = (take && valid_q) ? key_q - key_i : '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      gap_q.took <= 1'b0;
      gap_q.lo   <= '1;
      gap_q.hi   <= '1;
    end else begin
      valid_q    <= valid_d;
      gap_q      <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.key   = key_q;
  assign gap_o        = gap_q;

endmodule

// ===== sim/tb_bounded_set_span_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_set_span_tracker
// Drives signed values into the span tracker under changing capacities and
// checks each result word against a sorted-store predictor in the bench or
// a typed row's word. A directed table opens the run, then random phases.
// ----------------------------------------------------------------------------
module tb_bounded_set_span_tracker;
  import bsst_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 500;

  localparam logic [ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  localparam logic ST_TAKEN = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  typedef struct packed {
    logic                 status;
    logic [OUT_CNT_W-1:0] count;
    logic                 spans_valid;
    logic [KEY_W-1:0]     shortest;
    logic [KEY_W-1:0]     longest;
  } span_word_t;

  typedef enum logic {ROW_VALUE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    bit                typed;
    span_word_t        want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     value_i;
  logic                 done_o;
  logic                 status_o;
  logic [OUT_CNT_W-1:0] count_o;
  logic                 spans_valid_o;
  logic [KEY_W-1:0]     shortest_span_o;
  logic [KEY_W-1:0]     longest_span_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // bench copy of the tracker state; keys are sign-flipped values
  logic [KEY_W-1:0] held_keys[$];
  logic [KEY_W-1:0] gap_min = '1;
  logic [KEY_W-1:0] key_lo  = '0;
  logic [KEY_W-1:0] key_hi  = '0;
  logic [CAP_W-1:0] cap_reg = '0;

  span_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;

  stim_row_t directed_rows [19] = '{
    '{ROW_VALUE, CAP_ADDR,   32'h0000_0000, 1'b1, '{ST_FULL, 7'd0, 1'b0, 32'd0, 32'd0}},
    '{ROW_VALUE, CAP_ADDR,   32'h8000_0000, 1'b1, '{ST_FULL, 7'd0, 1'b0, 32'd0, 32'd0}},
    '{ROW_CFG,   SPARE_ADDR, 32'h0000_0005, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h7FFF_FFFF, 1'b1, '{ST_FULL, 7'd0, 1'b0, 32'd0, 32'd0}},
    '{ROW_CFG,   CAP_ADDR,   32'hFFFF_FF7F, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h8000_0000, 1'b1, '{ST_TAKEN, 7'd1, 1'b0, 32'd0, 32'd0}},
    '{ROW_VALUE, CAP_ADDR,   32'h7FFF_FFFF, 1'b1,
      '{ST_TAKEN, 7'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{ROW_VALUE, CAP_ADDR,   32'h0000_0000, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h0000_0000, 1'b1,
      '{ST_TAKEN, 7'd4, 1'b1, 32'd0, 32'hFFFF_FFFF}},
    '{ROW_VALUE, CAP_ADDR,   32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h0000_0001, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h5555_5555, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_CFG,   CAP_ADDR,   32'h0000_0002, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h0000_0005, 1'b1,
      '{ST_FULL, 7'd8, 1'b1, 32'd0, 32'hFFFF_FFFF}},
    '{ROW_CFG,   CAP_ADDR,   32'h0000_0000, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'h1234_5678, 1'b1,
      '{ST_FULL, 7'd8, 1'b1, 32'd0, 32'hFFFF_FFFF}},
    '{ROW_CFG,   CAP_ADDR,   32'h0000_0040, 1'b0, '0},
    '{ROW_VALUE, CAP_ADDR,   32'hFFFF_FFFE, 1'b0, '0}
  };

  bounded_set_span_tracker uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .spans_valid_o   (spans_valid_o),
    .shortest_span_o (shortest_span_o),
    .longest_span_o  (longest_span_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // sorted insertion with running gap, least and greatest key
  function automatic span_word_t predict_span(input logic [KEY_W-1:0] v);
    span_word_t       w;
    int               limit;
    int               pos;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] diff;
    w     = '0;
    limit = (int'(cap_reg) < MAX_ENTRIES) ? int'(cap_reg) : MAX_ENTRIES;
    key   = v ^ SIGN_BIAS;
    if (held_keys.size() >= limit) begin
      w.status = ST_FULL;
    end else begin
      w.status = ST_TAKEN;
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
      if (pos > 0) begin
        diff = key - held_keys[pos-1];
        if (diff < gap_min) gap_min = diff;
      end
      if (pos < held_keys.size()) begin
        diff = held_keys[pos] - key;
        if (diff < gap_min) gap_min = diff;
      end
      if (held_keys.size() == 0) begin
        key_lo = key;
        key_hi = key;
      end else begin
        if (key < key_lo) key_lo = key;
        if (key > key_hi) key_hi = key;
      end
      held_keys.insert(pos, key);
    end
    w.count = OUT_CNT_W'(held_keys.size());
    if (held_keys.size() >= 2) begin
      w.spans_valid = 1'b1;
      w.shortest    = gap_min;
      w.longest     = key_hi - key_lo;
    end
    return w;
  endfunction

  // mostly short gaps, now and then a long one; none inside a burst
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 19);
    if (burst || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // full range, near a held value, extremes, or close to zero
  function automatic logic [KEY_W-1:0] pick_value();
    int               r;
    logic [KEY_W-1:0] base;
    r = $urandom_range(0, 9);
    if (r >= 4 && r <= 6 && held_keys.size() > 0) begin
      base = held_keys[$urandom_range(0, held_keys.size() - 1)] ^ SIGN_BIAS;
      return base + 32'($urandom_range(0, 8)) - 32'd4;
    end
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r >= 8) return 32'($urandom_range(0, 40)) - 32'd20;
    return $urandom;
  endfunction

  // entered and left at a falling edge; start stays high when gap is zero
  task automatic send_value(input logic [KEY_W-1:0] v, input bit typed,
                            input span_word_t want, input int gap);
    span_word_t w;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    w = predict_span(v);
    expected_words.insert(expected_words.size(), typed ? want : w);
    @(negedge clk_i);
  endtask

  // only with the tracker idle; reads capacity back afterwards
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2] == REG_CAPACITY) cap_reg = data[CAP_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAP_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(cap_reg)) report_mismatch("capacity readback", prdata,
                                                     DATA_W'(cap_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    span_word_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected", 32'(count_o), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (count_o !== want.count)
          report_mismatch("count", 32'(count_o), 32'(want.count));
        if (spans_valid_o !== want.spans_valid)
          report_mismatch("spans_valid", 32'(spans_valid_o), 32'(want.spans_valid));
        if (shortest_span_o !== want.shortest)
          report_mismatch("shortest_span", shortest_span_o, want.shortest);
        if (longest_span_o !== want.longest)
          report_mismatch("longest_span", longest_span_o, want.longest);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bounded_set_span_tracker: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int               sent;
    int               batch;
    int               pick;
    bit               burst;
    logic [CAP_W-1:0] cap;
    logic [DATA_W-1:0] data;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      else
        send_value(directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].want, pick_gap(1'b0));
    end

    // random phases: capacity usually creeps up a little past the count,
    // so the store fills gradually and the full case recurs often
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0)      cap = '0;
      else if (pick == 1) cap = 7'd127;
      else if (pick == 2) cap = 7'(MAX_ENTRIES);
      else cap = 7'((held_keys.size() + $urandom_range(0, 6) > 127) ? 127 :
                    held_keys.size() + $urandom_range(0, 6));
      data = DATA_W'(cap);
      if ($urandom_range(0, 3) == 0) data = ($urandom & 32'hFFFF_FF80) | data;
      write_reg(CAP_ADDR, data);
      burst = ($urandom_range(0, 3) == 0);
      batch = $urandom_range(10, 40);
      repeat (batch) begin
        send_value(pick_value(), 1'b0, '0, pick_gap(burst));
        sent++;
      end
    end

    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0)
      $display("tb_bounded_set_span_tracker: done, clean");
    else
      $display("tb_bounded_set_span_tracker: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bsst_pkg.sv
hdl/bsst_cell.sv
hdl/bounded_set_span_tracker.sv
sim/tb_bounded_set_span_tracker.sv
